// File: sv/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants for the packet deframer with CRC-16 check.
// ----------------------------------------------------------------------------
package pdc_pkg;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [1:0] KIND_CRC_BAD  = 2'd2;
    localparam logic [1:0] KIND_TOO_LONG = 2'd3;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_OPCODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_OPCODE = 2'd1;

    // reset values of the opcode registers
    localparam logic [7:0] READ_OPCODE_RST  = 8'h00;
    localparam logic [7:0] WRITE_OPCODE_RST = 8'h01;

    // default depth of the queue between parser and output stage
    localparam int QUEUE_DEPTH_DEF = 4;

    // one result transaction as it travels through the queue
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  rw_code;
        logic [15:0] command_word;
        logic [15:0] payload_length;
    } result_t;

endpackage

// File: sv/pdc_parser.sv
// ----------------------------------------------------------------------------
// pdc_parser
// Front end: hunts the frame header, parses the fields, runs the CRC-16-CCITT
// and pushes payload bytes and packet verdicts into the result queue.
// ----------------------------------------------------------------------------
module pdc_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [pdc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    // received bytes
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,
    // result queue push side
    input  logic                            q_full,
    output logic                            q_push,
    output pdc_pkg::result_t                q_data
);

    // parse states
    localparam logic [2:0] ST_HUNT = 3'd0;
    localparam logic [2:0] ST_RW   = 3'd1;
    localparam logic [2:0] ST_CMD  = 3'd2;
    localparam logic [2:0] ST_LEN  = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;
    localparam logic [2:0] ST_CRC  = 3'd5;

    localparam logic [7:0]  HDR_FIRST  = 8'h55;
    localparam logic [7:0]  HDR_SECOND = 8'hAA;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] LEN_LIMIT  = 16'd255;

    // byte-wise crc-16-ccitt update
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = {c[7:0], c[15:8]} ^ {8'h00, b};
        x = x ^ {12'h000, x[7:4]};
        x = x ^ {x[3:0], 12'h000};
        x = x ^ {3'b000, x[7:0], 5'b00000};
        return x;
    endfunction

    localparam logic [15:0] HDR_CRC = crc_byte(crc_byte(CRC_INIT, HDR_FIRST), HDR_SECOND);

    logic [7:0]  read_op_reg;
    logic [7:0]  write_op_reg;
    logic [2:0]  state_reg, state_next;
    logic        second_reg, second_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  remain_reg, remain_next;
    logic [7:0]  rw_reg, rw_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic        accept;
    logic [15:0] crc_upd;
    logic [15:0] len_full;
    logic [7:0]  remain_dec;

    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign crc_upd    = crc_byte(crc_reg, rx_byte);
    assign len_full   = {rx_byte, len_reg[7:0]};
    assign remain_dec = remain_reg - 8'd1;

    // opcode registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_op_reg  <= pdc_pkg::READ_OPCODE_RST;
            write_op_reg <= pdc_pkg::WRITE_OPCODE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == pdc_pkg::CFG_READ_OPCODE)
                read_op_reg <= cfg_data;
            else if (cfg_index == pdc_pkg::CFG_WRITE_OPCODE)
                write_op_reg <= cfg_data;
        end
    end

    // frame parse and result generation
    always_comb
    begin
        state_next   = state_reg;
        second_next  = second_reg;
        crc_next     = crc_reg;
        remain_next  = remain_reg;
        rw_next      = rw_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        crc_low_next = crc_low_reg;
        q_push       = 1'b0;
        q_data.kind           = pdc_pkg::KIND_PAYLOAD;
        q_data.payload_byte   = 8'h00;
        q_data.rw_code        = rw_reg;
        q_data.command_word   = cmd_reg;
        q_data.payload_length = len_reg;
        if (accept)
        begin
            unique case (state_reg)
                ST_RW:
                begin
                    if (rx_byte == read_op_reg || rx_byte == write_op_reg)
                    begin
                        rw_next    = rx_byte;
                        crc_next   = crc_upd;
                        state_next = ST_CMD;
                    end
                    else
                        state_next = ST_HUNT;
                end
                ST_CMD:
                begin
                    crc_next = crc_upd;
                    if (!second_reg)
                    begin
                        cmd_next    = {8'h00, rx_byte};
                        second_next = 1'b1;
                    end
                    else
                    begin
                        cmd_next    = {rx_byte, cmd_reg[7:0]};
                        second_next = 1'b0;
                        state_next  = ST_LEN;
                    end
                end
                ST_LEN:
                begin
                    if (!second_reg)
                    begin
                        len_next    = {8'h00, rx_byte};
                        crc_next    = crc_upd;
                        second_next = 1'b1;
                    end
                    else
                    begin
                        len_next    = len_full;
                        second_next = 1'b0;
                        if (len_full >= LEN_LIMIT)
                        begin
                            // oversize length: drop frame, report it
                            state_next            = ST_HUNT;
                            q_push                = 1'b1;
                            q_data.kind           = pdc_pkg::KIND_TOO_LONG;
                            q_data.payload_length = len_full;
                        end
                        else
                        begin
                            crc_next    = crc_upd;
                            remain_next = len_full[7:0];
                            state_next  = (len_full == 16'd0) ? ST_CRC : ST_DATA;
                        end
                    end
                end
                ST_DATA:
                begin
                    crc_next    = crc_upd;
                    remain_next = remain_dec;
                    if (remain_dec == 8'd0)
                        state_next = ST_CRC;
                    q_push              = 1'b1;
                    q_data.payload_byte = rx_byte;
                end
                ST_CRC:
                begin
                    if (!second_reg)
                    begin
                        crc_low_next = rx_byte;
                        second_next  = 1'b1;
                    end
                    else
                    begin
                        second_next = 1'b0;
                        state_next  = ST_HUNT;
                        q_push      = 1'b1;
                        q_data.kind = ({rx_byte, crc_low_reg} == crc_reg) ?
                                      pdc_pkg::KIND_ACCEPTED : pdc_pkg::KIND_CRC_BAD;
                    end
                end
                default:
                begin
                    // header hunt, also taken for unused codes
                    state_next = ST_HUNT;
                    if (second_reg)
                    begin
                        if (rx_byte == HDR_SECOND)
                        begin
                            crc_next   = HDR_CRC;
                            state_next = ST_RW;
                        end
                        second_next = 1'b0;
                    end
                    else if (rx_byte == HDR_FIRST)
                        second_next = 1'b1;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_HUNT;
            second_reg  <= 1'b0;
            crc_reg     <= CRC_INIT;
            remain_reg  <= 8'h00;
            rw_reg      <= 8'h00;
            cmd_reg     <= 16'h0000;
            len_reg     <= 16'h0000;
            crc_low_reg <= 8'h00;
        end
        else
        begin
            state_reg   <= state_next;
            second_reg  <= second_next;
            crc_reg     <= crc_next;
            remain_reg  <= remain_next;
            rw_reg      <= rw_next;
            cmd_reg     <= cmd_next;
            len_reg     <= len_next;
            crc_low_reg <= crc_low_next;
        end
    end

endmodule

// File: sv/pdc_queue.sv
// ----------------------------------------------------------------------------
// pdc_queue
// Short result queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module pdc_queue #(
    parameter int DEPTH = pdc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  pdc_pkg::result_t             push_data,
    output logic                         full,
    input  logic                         pop,
    output pdc_pkg::result_t             pop_data,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    pdc_pkg::result_t entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: sv/pdc_out_stage.sv
// ----------------------------------------------------------------------------
// pdc_out_stage
// Back end: output register that takes results from the queue and holds
// each one until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module pdc_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  pdc_pkg::result_t q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output pdc_pkg::result_t out_data
);

    logic             valid_reg;
    pdc_pkg::result_t data_reg;

    // load when the register is free or being drained
    assign q_pop     = !q_empty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= q_data;
    end

endmodule

// File: sv/packet_deframer_crc16_check_unit.sv
// A byte that produces a result writes it into the result queue, and the output
// register loads it from there once that register is free or being drained.
// Throughput: one received byte per cycle; the input stalls only while the
// result queue is full, which happens when the downstream side stalls.
// Reset: asynchronous, active low; parser returns to header hunt, CRC to 0xFFFF,
// opcodes to 0 and 1, queue and output register empty.
// ----------------------------------------------------------------------------
// packet_deframer_crc16_check_unit
// Deframes 0x55 0xAA packets byte by byte, emits payload bytes and a final
// accepted / rejected verdict checked against a CRC-16-CCITT.
// ----------------------------------------------------------------------------
module packet_deframer_crc16_check_unit #(
    parameter int QUEUE_DEPTH = pdc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pdc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    // received bytes
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,
    // results
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      out_kind,
    output logic [7:0]                      payload_byte,
    output logic [7:0]                      rw_code,
    output logic [15:0]                     command_word,
    output logic [15:0]                     payload_length
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [CW-1:0]    q_count;
    pdc_pkg::result_t q_wdata;
    pdc_pkg::result_t q_rdata;
    pdc_pkg::result_t out_data;

    assign cfg_ready = 1'b1;

    // front end
    pdc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    // result queue
    pdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty),
        .count     (q_count)
    );

    // back end
    pdc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign out_kind       = out_data.kind;
    assign payload_byte   = out_data.payload_byte;
    assign rw_code        = out_data.rw_code;
    assign command_word   = out_data.command_word;
    assign payload_length = out_data.payload_length;

    // queue never overflows
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("result pushed into full queue");

    // fill count stays within depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

    // a waiting result reaches the empty output register next cycle
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && !out_valid) |=> out_valid)
        else $error("queued result not loaded into output register");

    // only payload bytes carry data
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind != pdc_pkg::KIND_PAYLOAD) |-> payload_byte == 8'h00)
        else $error("verdict transaction carries a data byte");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packet deframer with CRC-16-CCITT check. Bytes
// are pushed through the deframer while a software deframer tracks the parse
// and CRC and queues the payload bytes and verdicts it should produce. Each
// output transaction is compared field by field. The bench mixes random
// gaps, random output stalls and long hold-offs with opcode changes.
// ----------------------------------------------------------------------------
module tb;

    // header bytes, length limit and CRC seed of the frame format
    localparam logic [7:0]  HDR_FIRST  = 8'h55;
    localparam logic [7:0]  HDR_SECOND = 8'hAA;
    localparam logic [15:0] LEN_LIMIT  = 16'd255;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    // run control
    localparam int DRAIN_CYCLES      = 4;
    localparam int FINAL_CYCLES      = 20;
    localparam int HOLD_CYCLES       = 80;
    localparam int FRAME_BYTE_TARGET = 1250;
    localparam int CYCLE_LIMIT       = 500000;

    typedef enum logic [2:0] {
        P_HUNT,
        P_RW,
        P_CMD,
        P_LEN,
        P_DATA,
        P_CRC
    } parse_state_t;

    // dut signals, all inputs known from time zero
    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pdc_pkg::CFG_INDEX_W-1:0] cfg_index = pdc_pkg::CFG_READ_OPCODE;
    logic [7:0]                      cfg_data  = 8'h00;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [7:0]                      rx_byte   = 8'h00;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [1:0]                      out_kind;
    logic [7:0]                      payload_byte;
    logic [7:0]                      rw_code;
    logic [15:0]                     command_word;
    logic [15:0]                     payload_length;

    // software deframer state
    parse_state_t p_state;
    logic         p_second;
    logic [15:0]  p_crc;
    logic [7:0]   p_remaining;
    logic [7:0]   p_rw;
    logic [15:0]  p_cmd;
    logic [15:0]  p_len;
    logic [7:0]   p_crc_low;
    logic [7:0]   rd_opcode;
    logic [7:0]   wr_opcode;

    pdc_pkg::result_t pending_results[$];

    // bookkeeping
    int  mismatches     = 0;
    int  results_seen   = 0;
    int  bytes_sent     = 0;
    int  n_payload      = 0;
    int  n_accepted     = 0;
    int  n_crc_bad      = 0;
    int  n_too_long     = 0;
    int  n_settings     = 0;
    int  n_holds        = 0;
    int  cycle_count    = 0;
    bit  calm           = 1'b0;
    int  hold_req       = 0;
    int  hold_ack       = 0;
    int  hold_left      = 0;
    int  seg_left       = 0;

    packet_deframer_crc16_check_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_kind       (out_kind),
        .payload_byte   (payload_byte),
        .rw_code        (rw_code),
        .command_word   (command_word),
        .payload_length (payload_length)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // byte-wise crc-16-ccitt update
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = {c[7:0], c[15:8]} ^ {8'h00, b};
        x = x ^ {12'h000, x[7:4]};
        x = x ^ {x[3:0], 12'h000};
        x = x ^ {3'b000, x[7:0], 5'b00000};
        return x;
    endfunction

    // queue one expected result with the held header fields
    task automatic push_result(input logic [1:0] kind, input logic [7:0] data);
        pdc_pkg::result_t r;
        r.kind           = kind;
        r.payload_byte   = data;
        r.rw_code        = p_rw;
        r.command_word   = p_cmd;
        r.payload_length = p_len;
        pending_results.push_back(r);
        case (kind)
            pdc_pkg::KIND_PAYLOAD:  n_payload++;
            pdc_pkg::KIND_ACCEPTED: n_accepted++;
            pdc_pkg::KIND_CRC_BAD:  n_crc_bad++;
            default:                n_too_long++;
        endcase
    endtask

    task automatic reset_deframer();
        p_state     = P_HUNT;
        p_second    = 1'b0;
        p_crc       = CRC_INIT;
        p_remaining = 8'h00;
        p_rw        = 8'h00;
        p_cmd       = 16'h0000;
        p_len       = 16'h0000;
        p_crc_low   = 8'h00;
        rd_opcode   = pdc_pkg::READ_OPCODE_RST;
        wr_opcode   = pdc_pkg::WRITE_OPCODE_RST;
    endtask

    // advance the software deframer by one accepted byte
    task automatic deframe_byte(input logic [7:0] b);
        case (p_state)
            P_RW:
            begin
                if (b == rd_opcode || b == wr_opcode)
                begin
                    p_rw    = b;
                    p_crc   = crc_step(p_crc, b);
                    p_state = P_CMD;
                end
                else
                    p_state = P_HUNT;
            end
            P_CMD:
            begin
                p_crc = crc_step(p_crc, b);
                if (!p_second)
                begin
                    p_cmd    = {8'h00, b};
                    p_second = 1'b1;
                end
                else
                begin
                    p_cmd[15:8] = b;
                    p_second    = 1'b0;
                    p_state     = P_LEN;
                end
            end
            P_LEN:
            begin
                if (!p_second)
                begin
                    p_len    = {8'h00, b};
                    p_crc    = crc_step(p_crc, b);
                    p_second = 1'b1;
                end
                else
                begin
                    p_len[15:8] = b;
                    p_second    = 1'b0;
                    if (p_len >= LEN_LIMIT)
                    begin
                        p_state = P_HUNT;
                        push_result(pdc_pkg::KIND_TOO_LONG, 8'h00);
                    end
                    else
                    begin
                        p_crc       = crc_step(p_crc, b);
                        p_remaining = p_len[7:0];
                        p_state     = (p_len == 16'd0) ? P_CRC : P_DATA;
                    end
                end
            end
            P_DATA:
            begin
                p_crc       = crc_step(p_crc, b);
                p_remaining = p_remaining - 8'd1;
                if (p_remaining == 8'd0)
                    p_state = P_CRC;
                push_result(pdc_pkg::KIND_PAYLOAD, b);
            end
            P_CRC:
            begin
                if (!p_second)
                begin
                    p_crc_low = b;
                    p_second  = 1'b1;
                end
                else
                begin
                    p_second = 1'b0;
                    p_state  = P_HUNT;
                    push_result(({b, p_crc_low} == p_crc) ?
                                pdc_pkg::KIND_ACCEPTED : pdc_pkg::KIND_CRC_BAD,
                                8'h00);
                end
            end
            default:
            begin
                // header hunt; a broken second byte is not reused as a first
                p_state = P_HUNT;
                if (p_second)
                begin
                    if (b == HDR_SECOND)
                    begin
                        p_crc   = crc_step(crc_step(CRC_INIT, HDR_FIRST), HDR_SECOND);
                        p_state = P_RW;
                    end
                    p_second = 1'b0;
                end
                else if (b == HDR_FIRST)
                    p_second = 1'b1;
            end
        endcase
    endtask

    // mismatch reporting
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("error at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // result checker, samples pre-edge values
    always @(posedge clk)
    begin : result_check
        pdc_pkg::result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result transaction with nothing expected, kind",
                                {14'd0, out_kind}, 16'hFFFF);
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                check_field("out_kind", {14'd0, out_kind}, {14'd0, want.kind});
                check_field("payload_byte", {8'd0, payload_byte}, {8'd0, want.payload_byte});
                check_field("rw_code", {8'd0, rw_code}, {8'd0, want.rw_code});
                check_field("command_word", command_word, want.command_word);
                check_field("payload_length", payload_length, want.payload_length);
            end
        end
    end

    // output stall: random segments, calm stretches and long hold-offs
    always @(posedge clk)
    begin : stall_gen
        int r;
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else if (seg_left != 0)
            seg_left <= seg_left - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                out_stall <= 1'b0;
                seg_left  <= $urandom_range(0, 6);
            end
            else if (r < 85)
            begin
                out_stall <= 1'b1;
                seg_left  <= $urandom_range(0, 2);
            end
            else if (r < 95)
            begin
                out_stall <= 1'b0;
                seg_left  <= $urandom_range(20, 60);
            end
            else
            begin
                out_stall <= 1'b1;
                seg_left  <= $urandom_range(10, 30);
            end
        end
    end

    // sender gap length, mostly short
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_unknown_opcode();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == rd_opcode || b == wr_opcode);
        return b;
    endfunction

    // send one byte transaction and track it once accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // build and send one frame; cut >= 0 sends only its first cut bytes
    task automatic send_frame(input logic [7:0] rw, input logic [15:0] cmd,
                              input logic [15:0] len, input bit bad_crc,
                              input int cut, inout int count);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        frame = {};
        frame.push_back(HDR_FIRST);
        frame.push_back(HDR_SECOND);
        frame.push_back(rw);
        frame.push_back(cmd[7:0]);
        frame.push_back(cmd[15:8]);
        frame.push_back(len[7:0]);
        frame.push_back(len[15:8]);
        if (len < LEN_LIMIT)
        begin
            for (int i = 0; i < len; i++)
                frame.push_back(8'($urandom));
            crc = CRC_INIT;
            foreach (frame[i])
                crc = crc_step(crc, frame[i]);
            if (bad_crc)
                crc = crc ^ (16'd1 << $urandom_range(0, 15));
            frame.push_back(crc[7:0]);
            frame.push_back(crc[15:8]);
        end
        foreach (frame[i])
        begin
            if (cut < 0 || i < cut)
            begin
                send_byte(frame[i]);
                count++;
            end
        end
    endtask

    // wait until every expected result has arrived, then let the parser settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write both opcode registers while idle
    task automatic write_opcodes(input logic [7:0] rd, input logic [7:0] wr);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= pdc_pkg::CFG_READ_OPCODE;
        cfg_data  <= rd;
        do
            @(posedge clk);
        while (!cfg_ready);
        rd_opcode = rd;
        cfg_index <= pdc_pkg::CFG_WRITE_OPCODE;
        cfg_data  <= wr;
        do
            @(posedge clk);
        while (!cfg_ready);
        wr_opcode = wr;
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // broken header: second byte is neither 0xaa nor a fresh start
    task automatic test_header_hunt();
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
    endtask

    // unknown opcode drops the frame without a result
    task automatic test_unknown_opcode();
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(8'h07);
    endtask

    // zero length, crc directly after the length, extreme byte values
    task automatic test_zero_length();
        int n;
        n = 0;
        send_frame(pdc_pkg::READ_OPCODE_RST, 16'hFFFF, 16'd0, 1'b0, -1, n);
    endtask

    // smallest length rejected as too long, equal to the limit
    task automatic test_length_limit();
        int n;
        n = 0;
        send_frame(pdc_pkg::WRITE_OPCODE_RST, 16'h0000, LEN_LIMIT, 1'b0, -1, n);
    endtask

    task automatic test_crc_mismatch();
        int n;
        n = 0;
        send_frame(pdc_pkg::WRITE_OPCODE_RST, 16'h1234, 16'd1, 1'b1, -1, n);
    endtask

    // several opcode settings, extremes included, each with a frame per code
    task automatic test_opcode_settings();
        logic [7:0] rd_list[6];
        logic [7:0] wr_list[6];
        int n;
        rd_list = '{8'hFF, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'h00};
        wr_list = '{8'h00, 8'hAA, 8'hAA, 8'hFF, 8'h00, 8'h00};
        rd_list[4] = 8'($urandom);
        wr_list[4] = 8'($urandom);
        wr_list[5] = pdc_pkg::WRITE_OPCODE_RST;
        n = 0;
        for (int s = 0; s < 6; s++)
        begin
            write_opcodes(rd_list[s], wr_list[s]);
            send_frame(rd_opcode, 16'($urandom), 16'($urandom_range(0, 6)),
                       $urandom_range(0, 4) == 0, -1, n);
            send_frame(wr_opcode, 16'($urandom), 16'($urandom_range(0, 6)),
                       $urandom_range(0, 4) == 0, -1, n);
            send_frame(pick_unknown_opcode(), 16'($urandom), 16'($urandom_range(0, 6)),
                       1'b0, -1, n);
        end
    endtask

    // hold the output off while the sender keeps pushing, then drain
    task automatic test_backpressure();
        int n;
        n = 0;
        calm     <= 1'b1;
        hold_req <= hold_req + 1;
        n_holds++;
        for (int f = 0; f < 3; f++)
            send_frame(wr_opcode, 16'($urandom), 16'd12, 1'b0, -1, n);
        wait_drained();
        calm <= 1'b0;
    endtask

    // bulk random traffic: mostly well-formed frames, some broken and noise
    task automatic test_random_traffic();
        int         frame_bytes;
        int         next_change;
        int         r;
        int         len;
        logic [7:0] rw;
        frame_bytes = 0;
        next_change = 250;
        send_frame(rd_opcode, 16'($urandom), 16'd254, 1'b0, -1, frame_bytes);
        while (frame_bytes < FRAME_BYTE_TARGET)
        begin
            // new opcode setting between phases, sometimes a hold-off
            if (frame_bytes >= next_change)
            begin
                next_change = frame_bytes + 250;
                r = $urandom_range(0, 7);
                case (r)
                    0:       write_opcodes(8'h00, 8'hFF);
                    1:       write_opcodes(8'hFF, 8'hFF);
                    default: write_opcodes(8'($urandom), 8'($urandom));
                endcase
                if ($urandom_range(0, 1) == 0)
                begin
                    hold_req <= hold_req + 1;
                    n_holds++;
                end
                calm <= ($urandom_range(0, 3) == 0);
            end
            rw = ($urandom_range(0, 1) == 0) ? rd_opcode : wr_opcode;
            r  = $urandom_range(0, 99);
            if (r < 70)
            begin
                len = $urandom_range(0, 99);
                if (len < 70)
                    len = $urandom_range(0, 8);
                else if (len < 98)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(240, 254);
                send_frame(rw, 16'($urandom), 16'(len), $urandom_range(0, 6) == 0, -1,
                           frame_bytes);
            end
            else if (r < 80)
            begin
                len = $urandom_range(0, 2);
                if (len == 0)
                    len = int'(LEN_LIMIT);
                else if (len == 1)
                    len = $urandom_range(256, 65535);
                else
                    len = int'({8'($urandom_range(1, 255)), 8'($urandom)});
                send_frame(rw, 16'($urandom), 16'(len), 1'b0, -1, frame_bytes);
            end
            else if (r < 85)
                send_frame(pick_unknown_opcode(), 16'($urandom), 16'($urandom_range(0, 4)),
                           1'b0, -1, frame_bytes);
            else if (r < 92)
                send_frame(rw, 16'($urandom), 16'($urandom_range(0, 8)), 1'b0,
                           $urandom_range(1, 7), frame_bytes);
            else
            begin
                // noise bytes, some of them false header starts
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_byte(($urandom_range(0, 3) == 0) ? HDR_FIRST : 8'($urandom));
            end
        end
        calm <= 1'b0;
    endtask

    // test sequence
    initial
    begin
        reset_deframer();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_hunt();
        test_unknown_opcode();
        test_zero_length();
        test_length_limit();
        test_crc_mismatch();
        test_opcode_settings();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (FINAL_CYCLES) @(posedge clk);
        $display("summary: %0d bytes in, %0d results checked (%0d payload, %0d accepted,",
                 bytes_sent, results_seen, n_payload, n_accepted);
        $display("summary: %0d crc mismatch, %0d too long), %0d opcode settings, %0d hold-offs",
                 n_crc_bad, n_too_long, n_settings, n_holds);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
sv/pdc_pkg.sv
sv/pdc_parser.sv
sv/pdc_queue.sv
sv/pdc_out_stage.sv
sv/packet_deframer_crc16_check_unit.sv
tb/tb.sv
